// ===== design/gbn_pkg.sv =====
`timescale 1ns / 1ps
package gbn_pkg;
    localparam int BUF_DEPTH   = 64;
    localparam int WINDOW_MAX  = 16;
    localparam int SEG_LEN_MAX = 1024;
    localparam int PTR_W  = $clog2(BUF_DEPTH);
    localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
    localparam int WIN_W  = 5;
    localparam int LEN_W  = 11;
    localparam int DLEN_W = 16;
    localparam int SEQ_W  = 32;
    localparam int ENT_W  = SEQ_W + LEN_W + SEQ_W;

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_ACK    = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_RESEND = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_SEGLEN  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [ENT_W-1:0] wdata;
        logic [PTR_W-1:0] raddr;
    } ring_req_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (32'(p) + 1 >= BUF_DEPTH) ? '0 : p + 1'b1;
    endfunction
endpackage

// ===== design/gbn_ring.sv =====
`timescale 1ns / 1ps
module gbn_ring (
    input  logic                    aclk,
    input  gbn_pkg::ring_req_t      req,
    output logic [gbn_pkg::ENT_W-1:0] rdata
);
    import gbn_pkg::*;
    logic [ENT_W-1:0] mem [BUF_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule

// ===== design/go_back_n_send_window.sv =====
`timescale 1ns / 1ps
// channel  dir  tdata (low->high)                          tuser  tlast
// s_       in   cmd[1:0] data_length[17:2] ack_seq[49:18]   -      -
// m_       out  kind[1:0] seq_num[33:2] seg_len[44:34] slot[50:45]  -  last
// cfg      in   cfg_index selects window_size/seg_len_cap/timeout_ticks
// One item at a time through a sequencer around one ring memory (one write,
// one registered read per cycle). Submit: the segments are first counted (the
// count stops as soon as the ring is short), then written, then comes the
// fill pass. Ack/tick/fill: each ring entry visited is read, then used.
// s_tready is low while busy; a stalled m_ holds the sequencer. Synchronous
// reset clears control only.
module go_back_n_send_window (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // cmd, data_length, ack_seq
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // kind, seq_num, seg_len, slot
    output logic        m_tlast,  // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import gbn_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_SPLIT = 8'b00000010,
        ST_FRD   = 8'b00000100,
        ST_FUSE  = 8'b00001000,
        ST_ARD   = 8'b00010000,
        ST_AUSE  = 8'b00100000,
        ST_TRD   = 8'b01000000,
        ST_TUSE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [WIN_W-1:0] win_reg;
    logic [LEN_W-1:0] msl_reg;
    logic [31:0] tmo_reg;
    logic [PTR_W-1:0] head_reg, tail_reg, unsent_reg, p_reg;
    logic [CNT_W-1:0] count_reg, uns_reg;
    logic [WIN_W-1:0] unack_reg;
    logic [SEQ_W-1:0] nseq_reg, now_reg, ack_reg;
    logic [DLEN_W-1:0] rem_reg;
    logic [DLEN_W-1:0] len_reg;
    logic [4:0] n_reg, i_reg;
    logic first_reg;
    logic [CNT_W-1:0] need_reg;
    logic [1:0] ph_reg;

    logic [WIN_W-1:0] win_eff;
    logic [LEN_W-1:0] msl_eff;
    logic [CNT_W-1:0] free_cnt;
    ring_req_t req;
    logic [ENT_W-1:0] rdata;
    logic [SEQ_W-1:0] r_seq, r_time;
    logic [LEN_W-1:0] r_len;

    assign win_eff = (win_reg == '0) ? WIN_W'(1) :
                     (32'(win_reg) > WINDOW_MAX) ? WIN_W'(WINDOW_MAX) : win_reg;
    assign msl_eff = (msl_reg == '0) ? LEN_W'(1) :
                     (32'(msl_reg) > SEG_LEN_MAX) ? LEN_W'(SEG_LEN_MAX) : msl_reg;
    assign free_cnt = CNT_W'(BUF_DEPTH) - count_reg;
    assign {r_seq, r_len, r_time} = rdata;

    gbn_ring u_ring (.aclk(aclk), .req(req), .rdata(rdata));

    assign s_tready  = (state_reg == ST_IDLE) && !m_tvalid;
    assign cfg_ready = 1'b1;

    logic fill_more;
    assign fill_more = (unack_reg < win_eff) && (uns_reg != '0) && (n_reg < 5'd16);

    always_comb begin
        req = '0;
        req.raddr = p_reg;
        case (state_reg)
            ST_SPLIT: begin
                req.we = (ph_reg == 2'd1) && (rem_reg != '0);
                req.waddr = tail_reg;
                req.wdata = {nseq_reg,
                             (32'(rem_reg) > 32'(msl_eff)) ? msl_eff : LEN_W'(rem_reg),
                             now_reg};
            end
            ST_FUSE: begin
                req.we = !m_tvalid;
                req.waddr = p_reg;
                req.wdata = {r_seq, r_len, now_reg};
            end
            ST_TUSE: begin
                req.we = !m_tvalid && !first_reg;
                req.waddr = p_reg;
                req.wdata = {r_seq, r_len, now_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            win_reg <= WIN_W'(16); msl_reg <= LEN_W'(1024); tmo_reg <= 32'd100;
            head_reg <= '0; tail_reg <= '0; unsent_reg <= '0;
            count_reg <= '0; uns_reg <= '0; unack_reg <= '0;
            nseq_reg <= '0; now_reg <= '0; m_tvalid <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_WINDOW:  win_reg <= cfg_data[WIN_W-1:0];
                    REG_SEGLEN:  msl_reg <= cfg_data[LEN_W-1:0];
                    REG_TIMEOUT: tmo_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: if (s_tvalid && s_tready) begin
                    n_reg <= '0;
                    case (s_tdata[1:0])
                        CMD_SUBMIT: begin
                            rem_reg <= s_tdata[17:2]; len_reg <= s_tdata[17:2];
                            need_reg <= '0;
                            ph_reg <= 2'd0; state_reg <= ST_SPLIT;
                        end
                        CMD_ACK: begin
                            ack_reg <= s_tdata[49:18]; p_reg <= head_reg;
                            state_reg <= ST_ARD;
                        end
                        CMD_TICK: begin
                            now_reg <= now_reg + 1'b1; p_reg <= head_reg;
                            i_reg <= '0; first_reg <= 1'b1; state_reg <= ST_TRD;
                        end
                        default: ;
                    endcase
                end
                ST_SPLIT: begin
                    if (ph_reg == 2'd0) begin
                        // count segments one per cycle, stop once the ring is short
                        if (rem_reg != '0 && need_reg >= free_cnt) begin
                            m_tdata <= {5'd0, tail_reg, LEN_W'(0), nseq_reg,
                                        KIND_REJECT};
                            m_tlast <= 1'b1; m_tvalid <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else if (rem_reg == '0) begin
                            rem_reg <= len_reg; ph_reg <= 2'd1;
                        end else begin
                            need_reg <= need_reg + 1'b1;
                            rem_reg <= (32'(rem_reg) > 32'(msl_eff)) ?
                                       rem_reg - DLEN_W'(msl_eff) : '0;
                        end
                    end else if (rem_reg == '0) begin
                        p_reg <= unsent_reg; state_reg <= ST_FRD;
                    end else begin
                        nseq_reg <= nseq_reg + SEQ_W'(req.wdata[SEQ_W+LEN_W-1 -: LEN_W]);
                        rem_reg <= rem_reg - DLEN_W'(req.wdata[SEQ_W+LEN_W-1 -: LEN_W]);
                        tail_reg <= ring_next(tail_reg);
                        count_reg <= count_reg + 1'b1;
                        uns_reg <= uns_reg + 1'b1;
                    end
                end
                ST_FRD: begin
                    if (!m_tvalid) begin
                        if (fill_more) state_reg <= ST_FUSE;
                        else begin
                            if (n_reg != '0) m_tlast <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_FUSE: if (!m_tvalid) begin
                    m_tdata <= {5'd0, p_reg, r_len, r_seq, KIND_FIRST};
                    m_tlast <= !((unack_reg + 1'b1 < win_eff) && (uns_reg != 1)
                                 && (n_reg < 5'd15));
                    m_tvalid <= 1'b1;
                    n_reg <= n_reg + 1'b1;
                    unsent_reg <= ring_next(p_reg); p_reg <= ring_next(p_reg);
                    uns_reg <= uns_reg - 1'b1; unack_reg <= unack_reg + 1'b1;
                    state_reg <= ST_FRD;
                end
                ST_ARD: state_reg <= ST_AUSE;
                ST_AUSE: begin
                    if (count_reg != '0 && r_seq < ack_reg) begin
                        if (unack_reg != '0) unack_reg <= unack_reg - 1'b1;
                        else begin
                            uns_reg <= uns_reg - 1'b1;
                            unsent_reg <= ring_next(unsent_reg);
                        end
                        head_reg <= ring_next(head_reg);
                        count_reg <= count_reg - 1'b1;
                        p_reg <= ring_next(p_reg);
                        state_reg <= ST_ARD;
                    end else begin
                        p_reg <= unsent_reg; state_reg <= ST_FRD;
                    end
                end
                ST_TRD: state_reg <= ST_TUSE;
                ST_TUSE: begin
                    if (first_reg) begin
                        first_reg <= 1'b0;
                        if (count_reg != '0 && unack_reg != '0 &&
                            (now_reg - r_time) > tmo_reg) state_reg <= ST_TUSE;
                        else state_reg <= ST_IDLE;
                    end else if (!m_tvalid) begin
                        m_tdata <= {5'd0, p_reg, r_len, r_seq, KIND_RESEND};
                        m_tlast <= !((5'(i_reg) + 1'b1 < unack_reg) && (i_reg < 5'd15));
                        m_tvalid <= 1'b1;
                        i_reg <= i_reg + 1'b1;
                        p_reg <= ring_next(p_reg);
                        if ((5'(i_reg) + 1'b1 < unack_reg) && (i_reg < 5'd15))
                            state_reg <= ST_TRD;
                        else state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
